[design/lbpf_pkg.sv]
// Shared types, constants and the blink pattern table for the LED pattern fader.
// Used by lbpf_div and led_blink_pattern_fader_top; depends on nothing else.
`default_nettype none

package lbpf_pkg;

   // Defaults for the top-level parameters.
   localparam int DUTY_FULL_DEF = 1023;
   localparam int FADE_INTERVAL_DEF = 10;

   // Fixed field widths.
   localparam int NOW_W = 32;
   localparam int DUR_W = 10;
   localparam int PAT_W = 3;
   localparam int PH_W = 2;
   localparam int LEN_W = 3;
   localparam int PWM_W = 10;
   localparam int DRIVE_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 3;

   // Pattern codes.
   localparam logic [PAT_W-1:0] PAT_OFF = 3'd0;
   localparam logic [PAT_W-1:0] PAT_ON = 3'd1;
   localparam logic [PAT_W-1:0] PAT_BLINK = 3'd2;
   localparam logic [PAT_W-1:0] PAT_BLINK_ONE = 3'd3;
   localparam logic [PAT_W-1:0] PAT_BLINK_TWO = 3'd4;
   localparam logic [PAT_W-1:0] PAT_ERROR = 3'd5;

   // Drive write codes.
   localparam logic [DRIVE_W-1:0] DRIVE_NONE = 2'd0;
   localparam logic [DRIVE_W-1:0] DRIVE_LEVEL = 2'd1;
   localparam logic [DRIVE_W-1:0] DRIVE_PWM = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH = 1'b1;

   typedef struct packed {
      logic             on;
      logic [DUR_W-1:0] dur;
   } phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Light level and duration of one phase of one pattern.
   function automatic phase_type pat_phase(logic [PAT_W-1:0] pat, logic [PH_W-1:0] ph);
      phase_type r;
      r.on = 1'b0;
      r.dur = '0;
      case (pat)
         PAT_ON: begin
            r.on = (ph == 2'd0);
         end
         PAT_BLINK: begin
            case (ph)
               2'd0: begin r.on = 1'b1; r.dur = 10'd500; end
               2'd1: begin r.on = 1'b0; r.dur = 10'd250; end
               default: begin r.on = 1'b0; r.dur = '0; end
            endcase
         end
         PAT_BLINK_ONE: begin
            case (ph)
               2'd0: begin r.on = 1'b1; r.dur = 10'd1000; end
               2'd1: begin r.on = 1'b0; r.dur = 10'd100; end
               2'd2: begin r.on = 1'b1; r.dur = 10'd100; end
               default: begin r.on = 1'b0; r.dur = '0; end
            endcase
         end
         PAT_BLINK_TWO: begin
            case (ph)
               2'd0: begin r.on = 1'b1; r.dur = 10'd1000; end
               2'd1: begin r.on = 1'b0; r.dur = 10'd100; end
               2'd2: begin r.on = 1'b1; r.dur = 10'd100; end
               default: begin r.on = 1'b0; r.dur = 10'd100; end
            endcase
         end
         PAT_ERROR: begin
            case (ph)
               2'd0: begin r.on = 1'b1; r.dur = 10'd100; end
               2'd1: begin r.on = 1'b0; r.dur = 10'd50; end
               2'd2: begin r.on = 1'b1; r.dur = 10'd100; end
               default: begin r.on = 1'b0; r.dur = 10'd50; end
            endcase
         end
         default: begin
            r.on = 1'b0;
            r.dur = '0;
         end
      endcase
      return r;
   endfunction

   // Number of phases in a pattern.
   function automatic logic [LEN_W-1:0] pat_len(logic [PAT_W-1:0] pat);
      logic [LEN_W-1:0] n;
      case (pat)
         PAT_BLINK: n = 3'd2;
         PAT_BLINK_ONE: n = 3'd3;
         PAT_BLINK_TWO: n = 3'd4;
         PAT_ERROR: n = 3'd4;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

[design/lbpf_div.sv]
// Iterative restoring divider, one quotient bit per cycle, for the fade duty ramp.
// Depends on lbpf_pkg for the status struct.
`default_nettype none

module lbpf_div #(
   parameter int QW = 10,
   parameter int DVW = 10
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [DVW+QW-1:0]           dividend,
   input  wire  [DVW-1:0]              divisor,
   output lbpf_pkg::div_stat_type      stat,
   output logic [QW-1:0]               quotient
);

   localparam int CW = $clog2(QW + 1);

   logic [DVW-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [QW-1:0]  dvd_ff, dvd_in, q_ff, q_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in, done_ff, done_in;
   logic [DVW:0]   trial, diff;
   logic           fits;

   // The dividend is known to give a quotient below 2**QW, so its upper part
   // already sits below the divisor and seeds the remainder.
   always_comb begin
      trial = {rem_ff, dvd_ff[QW-1]};
      diff = trial - {1'b0, dvsr_ff};
      fits = (trial >= {1'b0, dvsr_ff});
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvsr_in = dvsr_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend[DVW+QW-1:QW];
         dvd_in = dividend[QW-1:0];
         dvsr_in = divisor;
         q_in = '0;
         cnt_in = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVW-1:0] : trial[DVW-1:0];
         dvd_in = QW'({dvd_ff, 1'b0});
         q_in = QW'({q_ff, fits});
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvsr_ff <= dvsr_in;
      q_ff <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient = q_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < dvsr_ff))
      else $error("divider remainder reached the divisor");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      !reset && busy_ff && !start && (cnt_ff == CW'(1)) |=> done_ff && !busy_ff)
      else $error("divider did not finish after its last step");
`endif

endmodule

`default_nettype wire

[design/led_blink_pattern_fader_top.sv]
// Top level of the LED blink pattern generator with linear PWM fades.
// Depends on lbpf_pkg and instantiates the iterative divider lbpf_div.
//
// Usage: each req transaction carries the current millisecond time in
// req_tdata. The block steps a fixed table of blink patterns and returns
// exactly one rsp transaction per request with the applied light level,
// the PWM duty written, the kind of drive write and the phase now in force.
// The csr port selects the pattern (index 0) and fade mode (index 1); any
// write restarts the pattern at its first phase and forces a level write
// on the next request. Write it only while no request is in flight.
// A level write, a saturated fade or a request without a fade update goes from
// acceptance straight to the output state. A fade update inside the ramp first
// passes through the multiply state and then the restoring divider, one quotient
// bit per cycle over clog2(DUTY_FULL+1) quotient bits, before the output state.
// One request is worked on at a time; req_tready is high only while the
// sequencer is idle. The response sits in an output register, so the next
// request is accepted even while rsp_tready holds the previous response
// back; the sequencer only waits for that register before delivering.
// Synchronous reset clears the pattern to off, fade mode off, the phase
// and time stamps to zero, and arms the forced first level write.
`default_nettype none

module led_blink_pattern_fader_top #(
   parameter int DUTY_FULL = lbpf_pkg::DUTY_FULL_DEF,
   parameter int FADE_INTERVAL_MS = lbpf_pkg::FADE_INTERVAL_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   // Request channel. tdata: now_ms[31:0].
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [lbpf_pkg::NOW_W-1:0]        req_tdata,
   // Response channel. tdata: led_level[0], pwm_duty[10:1], drive_write[12:11],
   // step_index[14:13], zero fill [15].
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [15:0]                       rsp_tdata,
   // Configuration write port.
   input  wire                               csr_we,
   input  wire  [lbpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [lbpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DW = $clog2(DUTY_FULL + 1);
   localparam int DUR_W = lbpf_pkg::DUR_W;
   localparam int PW = DUR_W + DW;
   localparam int NOW_W = lbpf_pkg::NOW_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [lbpf_pkg::PAT_W-1:0]    pattern_ff, pattern_in;
   logic                          smooth_ff, smooth_in;
   logic [lbpf_pkg::PH_W-1:0]     phase_ff, phase_in;
   logic                          light_ff, light_in;
   logic                          restart_ff, restart_in;
   logic [NOW_W-1:0]              start_ms_ff, start_ms_in;
   logic [NOW_W-1:0]              fupd_ms_ff, fupd_ms_in;
   logic [DUR_W-1:0]              e_ff, e_in;
   logic [DUR_W-1:0]              dur_ff, dur_in;
   logic [DW-1:0]                 res_duty_ff, res_duty_in;
   logic [lbpf_pkg::DRIVE_W-1:0]  res_drive_ff, res_drive_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_level_ff, out_level_in;
   logic [DW-1:0]                 out_duty_ff, out_duty_in;
   logic [lbpf_pkg::DRIVE_W-1:0]  out_drive_ff, out_drive_in;
   logic [lbpf_pkg::PH_W-1:0]     out_step_ff, out_step_in;

   logic                          accept;
   logic [lbpf_pkg::PAT_W-1:0]    pat_eff;
   lbpf_pkg::phase_type           cur;
   logic [NOW_W-1:0]              since_fupd, since_start, elapsed;
   logic                          fade_due;
   logic [lbpf_pkg::LEN_W-1:0]    next_ph;
   logic                          div_start;
   logic [PW-1:0]                 product;
   lbpf_pkg::div_stat_type        div_stat;
   logic [DW-1:0]                 quotient;
   logic [DW+lbpf_pkg::PWM_W-1:0] duty_wide;

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // Unused pattern codes fall back to the off pattern.
   assign pat_eff = (pattern_ff <= lbpf_pkg::PAT_ERROR) ? pattern_ff : lbpf_pkg::PAT_OFF;
   assign cur = lbpf_pkg::pat_phase(pat_eff, phase_ff);
   assign since_fupd = req_tdata - fupd_ms_ff;
   assign since_start = req_tdata - start_ms_ff;
   // Time at the previous duty write, measured from the phase start.
   assign elapsed = fupd_ms_ff - start_ms_ff;
   assign fade_due = (cur.dur != '0) && smooth_ff && (since_fupd > NOW_W'(FADE_INTERVAL_MS));
   assign next_ph = {1'b0, phase_ff} + lbpf_pkg::LEN_W'(1);

   // The ramp only reaches the divider when the elapsed time is below the
   // duration, so it fits the duration width and the quotient fits DW bits.
   assign div_start = (state_ff == S_MUL);
   assign product = PW'(e_ff) * PW'(DUTY_FULL);

   lbpf_div #(
      .QW (DW),
      .DVW(DUR_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(product),
      .divisor (dur_ff),
      .stat    (div_stat),
      .quotient(quotient)
   );

   always_comb begin
      state_in = state_ff;
      pattern_in = pattern_ff;
      smooth_in = smooth_ff;
      phase_in = phase_ff;
      light_in = light_ff;
      restart_in = restart_ff;
      start_ms_in = start_ms_ff;
      fupd_ms_in = fupd_ms_ff;
      e_in = e_ff;
      dur_in = dur_ff;
      res_duty_in = res_duty_ff;
      res_drive_in = res_drive_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_level_in = out_level_ff;
      out_duty_in = out_duty_ff;
      out_drive_in = out_drive_ff;
      out_step_in = out_step_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_OUT;
               if (restart_ff || (light_ff != cur.on)) begin
                  // Level change or forced write: apply it and restart both time stamps.
                  light_in = cur.on;
                  start_ms_in = req_tdata;
                  fupd_ms_in = req_tdata;
                  restart_in = 1'b0;
                  res_drive_in = smooth_ff ? lbpf_pkg::DRIVE_PWM : lbpf_pkg::DRIVE_LEVEL;
                  res_duty_in = (smooth_ff && !cur.on) ? DW'(DUTY_FULL) : '0;
               end else begin
                  res_drive_in = lbpf_pkg::DRIVE_NONE;
                  res_duty_in = '0;
                  if (fade_due) begin
                     fupd_ms_in = req_tdata;
                     res_drive_in = lbpf_pkg::DRIVE_PWM;
                     if (elapsed >= NOW_W'(cur.dur)) begin
                        // Ramp saturated; an off phase inverts it to zero.
                        res_duty_in = cur.on ? DW'(DUTY_FULL) : '0;
                     end else begin
                        e_in = elapsed[DUR_W-1:0];
                        dur_in = cur.dur;
                        state_in = S_MUL;
                     end
                  end
                  if (since_start >= NOW_W'(cur.dur)) begin
                     phase_in = (next_ph < lbpf_pkg::pat_len(pat_eff)) ?
                                next_ph[lbpf_pkg::PH_W-1:0] : '0;
                  end
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               res_duty_in = light_ff ? quotient : (DW'(DUTY_FULL) - quotient);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_level_in = light_ff;
               out_duty_in = res_duty_ff;
               out_drive_in = res_drive_ff;
               out_step_in = phase_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes restart the pattern.
      if (csr_we) begin
         case (csr_index)
            lbpf_pkg::CSR_PATTERN: pattern_in = csr_wdata;
            lbpf_pkg::CSR_SMOOTH: smooth_in = csr_wdata[0];
            default: pattern_in = pattern_ff;
         endcase
         phase_in = '0;
         restart_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pattern_ff <= lbpf_pkg::PAT_OFF;
         smooth_ff <= 1'b0;
         phase_ff <= '0;
         light_ff <= 1'b0;
         restart_ff <= 1'b1;
         start_ms_ff <= '0;
         fupd_ms_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pattern_ff <= pattern_in;
         smooth_ff <= smooth_in;
         phase_ff <= phase_in;
         light_ff <= light_in;
         restart_ff <= restart_in;
         start_ms_ff <= start_ms_in;
         fupd_ms_ff <= fupd_ms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff <= e_in;
      dur_ff <= dur_in;
      res_duty_ff <= res_duty_in;
      res_drive_ff <= res_drive_in;
      out_level_ff <= out_level_in;
      out_duty_ff <= out_duty_in;
      out_drive_ff <= out_drive_in;
      out_step_ff <= out_step_in;
   end

   // The duty port carries the low ten bits of the duty.
   assign duty_wide = {{lbpf_pkg::PWM_W{1'b0}}, out_duty_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, out_step_ff, out_drive_ff, duty_wide[lbpf_pkg::PWM_W-1:0],
                       out_level_ff};

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_tready)
      else $error("request accepted while the divider is busy");
   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      !reset && csr_we |=> restart_ff && (phase_ff == '0))
      else $error("configuration write did not restart the pattern");
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      !reset && accept && restart_ff && !csr_we |=> !restart_ff)
      else $error("forced level write not consumed");
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the LED blink pattern fader, led_blink_pattern_fader_top.
// Needs lbpf_pkg and the design sources; holds its own model of the pattern stepper
// and PWM fade ramp inside a small scoreboard class.
`timescale 1ns / 100ps

module testbench;
   import lbpf_pkg::*;

   // Register settling time after the last response; it leaves a clear margin over
   // the time that a fade update takes.
   localparam int SETTLE_CYCLES = 24;

   // One response transaction, split into its fields.
   typedef struct {
      logic             level;
      logic [PWM_W-1:0] duty;
      logic [1:0]       drive;
      logic [PH_W-1:0]  step;
   } fader_update;

   // The scoreboard keeps its own copy of the registers and of the sequencer state.
   // Every accepted request is run through the model right away and the resulting
   // update is queued; every accepted response is compared with the oldest one.
   class fader_scoreboard;
      logic [PAT_W-1:0] pattern_sel;
      bit               fade_mode;
      logic [PH_W-1:0]  phase;
      bit               light;
      logic [31:0]      phase_start_ms;
      logic [31:0]      last_duty_ms;
      bit               restart;
      fader_update      expected_updates[$];
      int               errors;
      int               checked;
      int               level_writes;
      int               duty_ramps;
      int               phase_steps;

      function new();
         pattern_sel = PAT_OFF;
         fade_mode = 1'b0;
         phase = '0;
         light = 1'b0;
         phase_start_ms = '0;
         last_duty_ms = '0;
         restart = 1'b1;
         errors = 0;
         checked = 0;
         level_writes = 0;
         duty_ramps = 0;
         phase_steps = 0;
      endfunction

      function int pending();
         return expected_updates.size();
      endfunction

      // Any register write restarts the pattern and forces a level write.
      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PATTERN)
            pattern_sel = data;
         else
            fade_mode = data[0];
         phase = '0;
         restart = 1'b1;
      endfunction

      // Light level, duration and length of the selected pattern. Unused codes
      // fall back to the off pattern.
      function void pattern_phase(input logic [PAT_W-1:0] p, input logic [PH_W-1:0] ph,
                                  output bit on, output int unsigned dur,
                                  output int unsigned len);
         on = 1'b0;
         dur = 0;
         len = 1;
         case (p)
            PAT_ON: begin
               on = (ph == 0);
            end
            PAT_BLINK: begin
               len = 2;
               on = (ph == 0);
               dur = (ph == 0) ? 500 : (ph == 1) ? 250 : 0;
            end
            PAT_BLINK_ONE: begin
               len = 3;
               on = (ph == 0) || (ph == 2);
               dur = (ph == 0) ? 1000 : (ph == 3) ? 0 : 100;
            end
            PAT_BLINK_TWO: begin
               len = 4;
               on = !ph[0];
               dur = (ph == 0) ? 1000 : 100;
            end
            PAT_ERROR: begin
               len = 4;
               on = !ph[0];
               dur = ph[0] ? 50 : 100;
            end
            default: begin
               on = 1'b0;
            end
         endcase
      endfunction

      function void accept_time(input logic [31:0] now);
         bit           lvl;
         int unsigned  dur;
         int unsigned  len;
         logic [31:0]  since_duty;
         logic [31:0]  since_start;
         logic [31:0]  elapsed;
         logic [63:0]  ramp;
         fader_update  upd;
         pattern_phase(pattern_sel, phase, lvl, dur, len);
         upd.duty = '0;
         upd.drive = DRIVE_NONE;
         if (restart || light != lvl) begin
            light = lvl;
            phase_start_ms = now;
            last_duty_ms = now;
            restart = 1'b0;
            level_writes++;
            if (fade_mode) begin
               upd.duty = lvl ? '0 : PWM_W'(DUTY_FULL_DEF);
               upd.drive = DRIVE_PWM;
            end else begin
               upd.drive = DRIVE_LEVEL;
            end
         end else begin
            since_duty = now - last_duty_ms;
            if (dur > 0 && fade_mode && since_duty > 32'(FADE_INTERVAL_DEF)) begin
               // The ramp uses the time of the previous duty write, not now.
               elapsed = last_duty_ms - phase_start_ms;
               ramp = (64'(elapsed) * 64'(DUTY_FULL_DEF)) / 64'(dur);
               if (ramp > 64'(DUTY_FULL_DEF))
                  ramp = 64'(DUTY_FULL_DEF);
               if (!lvl)
                  ramp = 64'(DUTY_FULL_DEF) - ramp;
               last_duty_ms = now;
               upd.duty = ramp[PWM_W-1:0];
               upd.drive = DRIVE_PWM;
               duty_ramps++;
            end
            since_start = now - phase_start_ms;
            if (since_start >= 32'(dur)) begin
               phase = (32'(phase) + 1 < len) ? phase + 1'b1 : '0;
               phase_steps++;
            end
         end
         upd.level = light;
         upd.step = phase;
         expected_updates.push_back(upd);
      endfunction

      function void check_update(input logic [15:0] data);
         fader_update want;
         if (expected_updates.size() == 0) begin
            $error("rsp: response 0x%04h arrived with no request outstanding", data);
            errors++;
            return;
         end
         want = expected_updates.pop_front();
         checked++;
         if (data[0] !== want.level) begin
            $error("led_level: expected %0d, got %0d", want.level, data[0]);
            errors++;
         end
         if (data[10:1] !== want.duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.duty, data[10:1]);
            errors++;
         end
         if (data[12:11] !== want.drive) begin
            $error("drive_write: expected %0d, got %0d", want.drive, data[12:11]);
            errors++;
         end
         if (data[14:13] !== want.step) begin
            $error("step_index: expected %0d, got %0d", want.step, data[14:13]);
            errors++;
         end
      endfunction
   endclass

   // Every block input starts at a known value.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [NOW_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // While calm is set neither side idles, which gives back-to-back traffic.
   bit                    calm = 1'b0;
   fader_scoreboard       sb = new();

   led_blink_pattern_fader_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver stalls in roughly 29 percent of cycles unless calm is set.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 29);
   end

   // Both channels are sampled at the rising edge. The response is checked before
   // the request of the same edge is noted, since it always belongs to an older one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_update(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.accept_time(req_tdata);
      end
   end

   // Offers one time stamp, with random idle cycles first, and returns at the
   // falling edge after the transaction. The valid stays high so that the next
   // call can follow without a gap.
   task automatic send_time(input logic [31:0] t);
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Each register write holds csr_we high for one cycle and drops it again before the task returns.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Holds the sender back until every expected response is in, then lets the
   // block settle so that registers can be written safely.
   task automatic wait_settled();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned      error_deltas[12];
      logic [31:0]      wall_ms;
      logic [PAT_W-1:0] pat;
      bit               fade;
      int               items;
      int unsigned      r;
      error_deltas = '{0, 10, 11, 40, 40, 30, 60, 5, 100, 100, 50, 50};

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Straight out of reset the off pattern is selected and the
      // first request must produce the forced level write; the time stamps sit
      // at both extremes.
      send_time(32'h0000_0000);
      send_time(32'hFFFF_FFFF);
      wait_settled();

      // Steady on pattern in fade mode: the level write has duty 0, and the zero
      // duration phase wraps onto itself on every later request.
      write_csr(CSR_PATTERN, PAT_ON);
      write_csr(CSR_SMOOTH, 3'b001);
      send_time(32'h8000_0000);
      send_time(32'h0000_0000);
      wait_settled();

      // Error pattern just below the wrap of the millisecond counter: fade steps
      // exactly at and just past the update interval, ramps inside each phase,
      // and phase advances that cross the wrap.
      write_csr(CSR_PATTERN, PAT_ERROR);
      wall_ms = 32'hFFFF_FFC0;
      foreach (error_deltas[i]) begin
         wall_ms = wall_ms + error_deltas[i];
         send_time(wall_ms);
      end
      wait_settled();

      // An unused pattern code behaves as off; only bit 0 of the fade register counts.
      write_csr(CSR_PATTERN, 3'd7);
      write_csr(CSR_SMOOTH, 3'b110);
      send_time(32'h5555_5555);
      send_time(32'hAAAA_AAAA);
      wait_settled();

      // Time running backwards makes the time since the phase start huge, so the phase
      // advances at once, while the ramp still uses the previous duty write time.
      write_csr(CSR_PATTERN, PAT_BLINK_TWO);
      write_csr(CSR_SMOOTH, 3'b001);
      send_time(32'd1000);
      send_time(32'd1020);
      send_time(32'd500);
      wait_settled();

      // Random part. The first eight settings walk through every pattern code with
      // alternating fade mode; the rest pick the timed patterns at random. Most
      // time stamps move forward in small steps so that whole patterns play out,
      // with jumps, backward steps and near-wrap values mixed in.
      for (int k = 0; k < 12; k++) begin
         pat = (k < 8) ? PAT_W'(k) : PAT_W'($urandom_range(PAT_BLINK, PAT_ERROR));
         fade = (k < 8) ? k[0] : 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_PATTERN, pat);
            write_csr(CSR_SMOOTH, {2'($urandom_range(0, 3)), fade});
         end else begin
            write_csr(CSR_SMOOTH, {2'($urandom_range(0, 3)), fade});
            write_csr(CSR_PATTERN, pat);
         end
         calm = (k == 9);
         items = (pat >= PAT_BLINK && pat <= PAT_ERROR) ? 160 : 40;
         wall_ms = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                             : $urandom();
         for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               wall_ms = wall_ms + $urandom_range(0, 25);
            else if (r < 80)
               wall_ms = wall_ms + $urandom_range(26, 400);
            else if (r < 88)
               wall_ms = $urandom();
            else if (r < 94)
               wall_ms = wall_ms - $urandom_range(1, 2000);
            else
               wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
            send_time(wall_ms);
            // Halfway through, the sender drains the block completely once.
            if (n == items / 2)
               wait_settled();
         end
         wait_settled();
         calm = 1'b0;
      end

      $display("Summary: %0d transactions checked, %0d level writes, %0d duty ramp updates,",
               sb.checked, sb.level_writes, sb.duty_ramps);
      $display("         %0d phase advances over all pattern codes and both fade modes.",
               sb.phase_steps);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // This time limit lies far beyond the length of a correct run.
   initial begin
      #2000000;
      $display("Timeout: %0d responses still outstanding", sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
